[src/mpb_pkg.sv]
package mpb_pkg;

	localparam int MAX_BOUNDARY_DEF = 32;
	localparam int LEN_W            = 6;
	localparam int WORD_W           = 64;
	localparam int CFG_IDX_W        = 3;

	localparam logic [7:0] CH_LF     = 8'd10;
	localparam logic [7:0] CH_CR     = 8'd13;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'd9;
	localparam logic [7:0] CH_HYPHEN = 8'h2d;
	localparam logic [7:0] CH_COLON  = 8'h3a;

	typedef enum logic [2:0] {
		REG_LEN   = 3'd0,
		REG_WORD0 = 3'd1,
		REG_WORD1 = 3'd2,
		REG_WORD2 = 3'd3,
		REG_WORD3 = 3'd4
	} cfg_reg_t;

	typedef enum logic [3:0] {
		K_NONE       = 4'd0,
		K_NAME       = 4'd1,
		K_NAME_END   = 4'd2,
		K_VALUE      = 4'd3,
		K_VALUE_END  = 4'd4,
		K_PART_BEGIN = 4'd5,
		K_HDR_DONE   = 4'd6,
		K_DATA       = 4'd7,
		K_PART_END   = 4'd8,
		K_BODY_END   = 4'd9,
		K_ERROR      = 4'd10
	} kind_t;

endpackage

[src/multipart_body_parser.sv]
// Byte-serial multipart body parser. Each accepted body byte is classified into one or more
// result requests (name byte, value byte, data byte, part and body delimiters, error), the last
// one flagged by last_of_run. A byte is taken into an input register and its result is
// registered into an output register, so one byte per cycle is sustained while the output
// is taken. The exception is a failed closing-boundary match: the held delimiter bytes are
// replayed as data one per cycle from a counter, so that byte yields one data result per
// held byte, plus one for the failing byte itself unless it is CR (at most 36 results), and
// input is stalled meanwhile. Errors are sticky until reset. Boundary registers may be
// written only while the parser is idle; writes take effect at once and do not restart parsing.
module multipart_body_parser
	import mpb_pkg::*;
#(
	parameter int MAX_BOUNDARY = MAX_BOUNDARY_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           body_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [3:0]           kind,
	output logic [7:0]           value,
	output logic                 last_of_run
);

	localparam int BIDX_W = (MAX_BOUNDARY > 1) ? $clog2(MAX_BOUNDARY) : 1;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BOUNDARY);

	typedef enum logic [11:0] {
		PH_START      = 12'b0000_0000_0001,
		PH_FIELD      = 12'b0000_0000_0010,
		PH_HDR_ALMOST = 12'b0000_0000_0100,
		PH_VAL_START  = 12'b0000_0000_1000,
		PH_VALUE      = 12'b0000_0001_0000,
		PH_VAL_ALMOST = 12'b0000_0010_0000,
		PH_DATA       = 12'b0000_0100_0000,
		PH_ALMOST_BND = 12'b0000_1000_0000,
		PH_ALMOST_END = 12'b0001_0000_0000,
		PH_HYPHEN     = 12'b0010_0000_0000,
		PH_DATA_END   = 12'b0100_0000_0000,
		PH_END        = 12'b1000_0000_0000
	} phase_t;

	logic [LEN_W-1:0] len_q;
	logic [7:0]       bnd_q [MAX_BOUNDARY];

	phase_t           phase_q, phase_n;
	logic [LEN_W-1:0] mpos_q, mpos_n;
	logic [LEN_W-1:0] rep_q, rep_n;
	logic             err_q, err_n;

	logic             valid_s1;
	logic [7:0]       byte_s1;

	logic             out_valid_q;
	kind_t            kind_q;
	logic [7:0]       value_q;
	logic             last_q;

	kind_t            r_kind;
	logic [7:0]       r_val;
	logic             r_last;

	logic             out_free, fire;
	logic [LEN_W-1:0] bl;
	logic [7:0]       cl;

	function automatic logic [7:0] bnd_byte(input logic [LEN_W-1:0] j);
		logic [7:0] b;
		b = 8'd0;
		if (j < MAX_LEN) begin
			b = bnd_q[j[BIDX_W-1:0]];
		end
		return b;
	endfunction

	function automatic logic [7:0] delim_char(input logic [LEN_W-1:0] k);
		logic [7:0] d;
		if (k == LEN_W'(0)) begin
			d = CH_CR;
		end else if (k == LEN_W'(1)) begin
			d = CH_LF;
		end else if (k < LEN_W'(4)) begin
			d = CH_HYPHEN;
		end else begin
			d = bnd_byte(k - LEN_W'(4));
		end
		return d;
	endfunction

	assign cfg_ready = 1'b1;

	// effective boundary length
	always_comb begin
		bl = len_q;
		if (len_q == LEN_W'(0)) begin
			bl = LEN_W'(1);
		end else if (len_q > MAX_LEN) begin
			bl = MAX_LEN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(1);
			for (int b = 0; b < MAX_BOUNDARY; b++) begin
				bnd_q[b] <= 8'd0;
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_LEN) begin
				len_q <= cfg_data[LEN_W-1:0];
			end
			for (int b = 0; b < MAX_BOUNDARY; b++) begin
				if ((cfg_index == REG_WORD0 && b / 8 == 0) ||
				    (cfg_index == REG_WORD1 && b / 8 == 1) ||
				    (cfg_index == REG_WORD2 && b / 8 == 2) ||
				    (cfg_index == REG_WORD3 && b / 8 == 3)) begin
					bnd_q[b] <= cfg_data[(b % 8) * 8 +: 8];
				end
			end
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign fire     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || (fire && r_last);
	assign cl       = byte_s1 | 8'h20;

	always_comb begin
		r_kind  = K_NONE;
		r_val   = 8'd0;
		r_last  = 1'b1;
		phase_n = phase_q;
		mpos_n  = mpos_q;
		rep_n   = rep_q;
		err_n   = err_q;
		if (err_q) begin
			r_kind = K_ERROR;
		end else begin
			unique case (phase_q)
				PH_START: begin
					if ({1'b0, mpos_q} < {1'b0, bl} + 7'd2) begin
						if (byte_s1 != delim_char(mpos_q + LEN_W'(2))) begin
							r_kind = K_ERROR;
							err_n  = 1'b1;
						end else begin
							mpos_n = mpos_q + LEN_W'(1);
						end
					end else if ({1'b0, mpos_q} == {1'b0, bl} + 7'd2) begin
						if (byte_s1 != CH_CR) begin
							r_kind = K_ERROR;
							err_n  = 1'b1;
						end else begin
							mpos_n = mpos_q + LEN_W'(1);
						end
					end else begin
						if (byte_s1 != CH_LF) begin
							r_kind = K_ERROR;
							err_n  = 1'b1;
						end else begin
							mpos_n  = LEN_W'(0);
							r_kind  = K_PART_BEGIN;
							phase_n = PH_FIELD;
						end
					end
				end
				PH_FIELD: begin
					if (byte_s1 == CH_HYPHEN || (cl >= 8'h61 && cl <= 8'h7a)) begin
						r_kind = K_NAME;
						r_val  = byte_s1;
					end else if (byte_s1 == CH_COLON) begin
						r_kind  = K_NAME_END;
						phase_n = PH_VAL_START;
					end else if (byte_s1 == CH_CR) begin
						phase_n = PH_HDR_ALMOST;
					end else begin
						r_kind = K_ERROR;
						err_n  = 1'b1;
					end
				end
				PH_HDR_ALMOST: begin
					if (byte_s1 != CH_LF) begin
						r_kind = K_ERROR;
						err_n  = 1'b1;
					end else begin
						r_kind  = K_HDR_DONE;
						phase_n = PH_DATA;
					end
				end
				PH_VAL_START, PH_VALUE: begin
					if (phase_q == PH_VAL_START &&
					    (byte_s1 == CH_SP || byte_s1 == CH_TAB)) begin
						r_kind = K_NONE;
					end else if (byte_s1 != CH_CR) begin
						r_kind  = K_VALUE;
						r_val   = byte_s1;
						phase_n = PH_VALUE;
					end else begin
						r_kind  = K_VALUE_END;
						phase_n = PH_VAL_ALMOST;
					end
				end
				PH_VAL_ALMOST: begin
					if (byte_s1 != CH_LF) begin
						r_kind = K_ERROR;
						err_n  = 1'b1;
					end else begin
						phase_n = PH_FIELD;
					end
				end
				PH_DATA: begin
					if (byte_s1 != CH_CR) begin
						r_kind = K_DATA;
						r_val  = byte_s1;
					end else begin
						phase_n = PH_ALMOST_BND;
						mpos_n  = LEN_W'(1);
					end
				end
				PH_ALMOST_BND: begin
					if (delim_char(mpos_q) == byte_s1) begin
						mpos_n = mpos_q + LEN_W'(1);
						if ({1'b0, mpos_q} + 7'd1 >= {1'b0, bl} + 7'd4) begin
							mpos_n  = LEN_W'(0);
							r_kind  = K_PART_END;
							phase_n = PH_ALMOST_END;
						end
					end else if (rep_q < mpos_q) begin
						// replay held delimiter bytes as data
						r_kind = K_DATA;
						r_val  = delim_char(rep_q);
						r_last = (rep_q + LEN_W'(1) == mpos_q) && (byte_s1 == CH_CR);
						if (r_last) begin
							rep_n  = LEN_W'(0);
							mpos_n = LEN_W'(1);
						end else begin
							rep_n = rep_q + LEN_W'(1);
						end
					end else begin
						r_kind  = K_DATA;
						r_val   = byte_s1;
						phase_n = PH_DATA;
						mpos_n  = LEN_W'(0);
						rep_n   = LEN_W'(0);
					end
				end
				PH_ALMOST_END: begin
					if (byte_s1 == CH_CR) begin
						phase_n = PH_DATA_END;
					end else if (byte_s1 == CH_HYPHEN) begin
						phase_n = PH_HYPHEN;
					end else begin
						r_kind = K_ERROR;
						err_n  = 1'b1;
					end
				end
				PH_HYPHEN: begin
					if (byte_s1 == CH_HYPHEN) begin
						r_kind  = K_BODY_END;
						phase_n = PH_END;
					end else begin
						r_kind = K_ERROR;
						err_n  = 1'b1;
					end
				end
				PH_DATA_END: begin
					if (byte_s1 == CH_LF) begin
						r_kind  = K_PART_BEGIN;
						phase_n = PH_FIELD;
					end else begin
						r_kind = K_ERROR;
						err_n  = 1'b1;
					end
				end
				PH_END: begin
					r_kind = K_NONE;
				end
				default: begin
					r_kind = K_ERROR;
					err_n  = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			mpos_q      <= LEN_W'(0);
			rep_q       <= LEN_W'(0);
			err_q       <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q <= phase_n;
				mpos_q  <= mpos_n;
				rep_q   <= rep_n;
				err_q   <= err_n;
			end
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (fire && r_last) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= fire;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= body_byte;
		end
		if (fire) begin
			kind_q  <= r_kind;
			value_q <= r_val;
			last_q  <= r_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign value       = value_q;
	assign last_of_run = last_q;

endmodule

[tb/sv/multipart_body_parser_test.sv]
module multipart_body_parser_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mpb_pkg::*;

	typedef enum logic [3:0] {
		ST_OPEN,
		ST_NAME,
		ST_HDR_LF,
		ST_VAL_LEAD,
		ST_VAL,
		ST_VAL_LF,
		ST_DATA,
		ST_DELIM,
		ST_AFTER_DELIM,
		ST_DASH,
		ST_NEXT_LF,
		ST_DONE
	} parse_state_t;

	typedef struct {
		kind_t      kind;
		logic [7:0] value;
		logic       last;
	} parse_event_t;

	typedef struct {
		logic [7:0] b;
		logic       typed;
		kind_t      kind;
		logic [7:0] value;
	} script_row_t;

	localparam logic [2:0] REG_SPARE = 3'd7;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           body_byte = 8'h00;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [3:0]           kind;
	logic [7:0]           value;
	logic                 last_of_run;

	parse_state_t pstate = ST_OPEN;
	int           mpos = 0;
	logic         err_seen = 1'b0;
	logic [5:0]   bnd_len = 6'd1;
	logic [63:0]  bnd_word [4] = '{default: 64'h0};

	parse_event_t byte_events[$];
	parse_event_t expected_events[$];
	parse_event_t want;
	logic         field_bad;
	int           mismatches = 0;
	int           bytes_sent = 0;
	int           burst_left = 0;
	int unsigned  stall_cycle = 0;
	int           stall_mode = 0;

	script_row_t script [29] = '{
		'{CH_HYPHEN, 1'b1, K_NONE,       8'h00},
		'{CH_HYPHEN, 1'b1, K_NONE,       8'h00},
		'{"B",       1'b1, K_NONE,       8'h00},
		'{CH_CR,     1'b1, K_NONE,       8'h00},
		'{CH_LF,     1'b1, K_PART_BEGIN, 8'h00},
		'{"A",       1'b1, K_NAME,       "A"},
		'{"z",       1'b1, K_NAME,       "z"},
		'{CH_HYPHEN, 1'b1, K_NAME,       CH_HYPHEN},
		'{CH_COLON,  1'b1, K_NAME_END,   8'h00},
		'{CH_SP,     1'b1, K_NONE,       8'h00},
		'{CH_TAB,    1'b1, K_NONE,       8'h00},
		'{8'h00,     1'b1, K_VALUE,      8'h00},
		'{8'hff,     1'b1, K_VALUE,      8'hff},
		'{CH_CR,     1'b1, K_VALUE_END,  8'h00},
		'{CH_LF,     1'b1, K_NONE,       8'h00},
		'{CH_COLON,  1'b1, K_NAME_END,   8'h00},
		'{CH_CR,     1'b1, K_VALUE_END,  8'h00},
		'{CH_LF,     1'b1, K_NONE,       8'h00},
		'{"k",       1'b1, K_NAME,       "k"},
		'{CH_CR,     1'b1, K_NONE,       8'h00},
		'{CH_LF,     1'b1, K_HDR_DONE,   8'h00},
		'{8'h00,     1'b1, K_DATA,       8'h00},
		'{8'hff,     1'b1, K_DATA,       8'hff},
		'{CH_CR,     1'b1, K_NONE,       8'h00},
		'{CH_LF,     1'b1, K_NONE,       8'h00},
		'{CH_CR,     1'b0, K_NONE,       8'h00},
		'{CH_LF,     1'b1, K_NONE,       8'h00},
		'{CH_HYPHEN, 1'b1, K_NONE,       8'h00},
		'{"7",       1'b0, K_NONE,       8'h00}
	};

	multipart_body_parser u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.body_byte  (body_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.value      (value),
		.last_of_run(last_of_run)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int bnd_len_eff();
		int n;
		n = bnd_len;
		if (n == 0) n = 1;
		if (n > MAX_BOUNDARY_DEF) n = MAX_BOUNDARY_DEF;
		return n;
	endfunction

	// CR LF "--" then the boundary characters
	function automatic logic [7:0] delim_byte(int k);
		int j;
		if (k == 0) return CH_CR;
		if (k == 1) return CH_LF;
		if (k < 4) return CH_HYPHEN;
		j = (k - 4) & 31;
		return bnd_word[j >> 3][8 * (j & 7) +: 8];
	endfunction

	function automatic void note(kind_t k, logic [7:0] v);
		parse_event_t e;
		e.kind = k;
		e.value = v;
		e.last = 1'b0;
		byte_events.push_back(e);
	endfunction

	function automatic void note_error();
		err_seen = 1'b1;
		note(K_ERROR, 8'h00);
	endfunction

	function automatic void classify_byte(logic [7:0] c);
		int bl;
		logic [7:0] cl;
		bl = bnd_len_eff();
		cl = c | 8'h20;
		byte_events.delete();
		if (err_seen) begin
			note(K_ERROR, 8'h00);
		end else begin
			case (pstate)
			ST_OPEN: begin
				if (mpos < bl + 2) begin
					if (c != delim_byte(mpos + 2)) note_error();
					else mpos++;
				end else if (mpos == bl + 2) begin
					if (c != CH_CR) note_error();
					else mpos++;
				end else if (c != CH_LF) begin
					note_error();
				end else begin
					mpos = 0;
					note(K_PART_BEGIN, 8'h00);
					pstate = ST_NAME;
				end
			end
			ST_NAME: begin
				if (c == CH_HYPHEN || (cl >= 8'h61 && cl <= 8'h7a)) begin
					note(K_NAME, c);
				end else if (c == CH_COLON) begin
					note(K_NAME_END, 8'h00);
					pstate = ST_VAL_LEAD;
				end else if (c == CH_CR) begin
					pstate = ST_HDR_LF;
				end else begin
					note_error();
				end
			end
			ST_HDR_LF: begin
				if (c != CH_LF) begin
					note_error();
				end else begin
					note(K_HDR_DONE, 8'h00);
					pstate = ST_DATA;
				end
			end
			ST_VAL_LEAD, ST_VAL: begin
				if (pstate == ST_VAL_LEAD && (c == CH_SP || c == CH_TAB)) begin
				end else if (c != CH_CR) begin
					note(K_VALUE, c);
					pstate = ST_VAL;
				end else begin
					note(K_VALUE_END, 8'h00);
					pstate = ST_VAL_LF;
				end
			end
			ST_VAL_LF: begin
				if (c != CH_LF) note_error();
				else pstate = ST_NAME;
			end
			ST_DATA: begin
				if (c != CH_CR) begin
					note(K_DATA, c);
				end else begin
					pstate = ST_DELIM;
					mpos = 1;
				end
			end
			ST_DELIM: begin
				if (mpos < 36 && delim_byte(mpos) == c) begin
					mpos++;
					if (mpos >= bl + 4) begin
						mpos = 0;
						note(K_PART_END, 8'h00);
						pstate = ST_AFTER_DELIM;
					end
				end else begin
					// held delimiter bytes go back out as data
					for (int k = 0; k < mpos && k < 35; k++) note(K_DATA, delim_byte(k));
					if (c != CH_CR) begin
						note(K_DATA, c);
						pstate = ST_DATA;
						mpos = 0;
					end else begin
						mpos = 1;
					end
				end
			end
			ST_AFTER_DELIM: begin
				if (c == CH_CR) pstate = ST_NEXT_LF;
				else if (c == CH_HYPHEN) pstate = ST_DASH;
				else note_error();
			end
			ST_DASH: begin
				if (c == CH_HYPHEN) begin
					note(K_BODY_END, 8'h00);
					pstate = ST_DONE;
				end else begin
					note_error();
				end
			end
			ST_NEXT_LF: begin
				if (c == CH_LF) begin
					note(K_PART_BEGIN, 8'h00);
					pstate = ST_NAME;
				end else begin
					note_error();
				end
			end
			ST_DONE: begin
			end
			default: note_error();
			endcase
		end
		if (byte_events.size() == 0) note(K_NONE, 8'h00);
		byte_events[byte_events.size() - 1].last = 1'b1;
	endfunction

	function automatic logic [7:0] rand_except(logic [7:0] x);
		logic [7:0] r;
		do r = 8'($urandom_range(0, 255)); while (r == x);
		return r;
	endfunction

	function automatic logic [7:0] name_char();
		case ($urandom_range(0, 2))
		0: return 8'($urandom_range(8'h41, 8'h5a));
		1: return 8'($urandom_range(8'h61, 8'h7a));
		default: return CH_HYPHEN;
		endcase
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		body_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic feed(input logic [7:0] b);
		send_byte(b);
		classify_byte(b);
		foreach (byte_events[i]) expected_events.push_back(byte_events[i]);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
		REG_LEN:   bnd_len = d[5:0];
		REG_WORD0: bnd_word[0] = d;
		REG_WORD1: bnd_word[1] = d;
		REG_WORD2: bnd_word[2] = d;
		REG_WORD3: bnd_word[3] = d;
		default: ;
		endcase
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input int ph);
		int n;
		case (ph)
		0: begin
			n = 1;
			write_reg(REG_WORD0, rand64());
			write_reg(REG_WORD1, rand64());
			write_reg(REG_WORD2, rand64());
			write_reg(REG_WORD3, rand64());
		end
		1: begin
			n = $urandom_range(2, 8);
			write_reg(REG_WORD0, rand64());
		end
		2: begin
			n = MAX_BOUNDARY_DEF;
			write_reg(REG_WORD0, rand64());
			write_reg(REG_WORD1, rand64());
			write_reg(REG_WORD2, rand64());
			write_reg(REG_WORD3, rand64());
		end
		3: begin
			n = 63;
			write_reg(REG_WORD0, '1);
			write_reg(REG_WORD1, '1);
			write_reg(REG_WORD2, '1);
			write_reg(REG_WORD3, '1);
		end
		4: begin
			n = 0;
			write_reg(REG_WORD0, '0);
			write_reg(REG_SPARE, rand64());
		end
		5: begin
			n = MAX_BOUNDARY_DEF + 1;
			write_reg(REG_WORD0, rand64());
			write_reg(REG_WORD2, rand64());
		end
		default: begin
			n = $urandom_range(1, 12);
			write_reg(REG_WORD0, rand64());
			write_reg(REG_WORD1, rand64());
		end
		endcase
		write_reg(REG_LEN, {$urandom, 26'($urandom), 6'(n)});
		cfg_valid <= 1'b0;
	endtask

	task automatic feed_delim(input int m);
		for (int k = 0; k < m; k++) feed(delim_byte(k));
	endtask

	// broken closing delimiter inside the data
	task automatic fake_delimiter();
		int bl;
		int m;
		logic [7:0] bad;
		bl = bnd_len_eff();
		m = ($urandom_range(0, 3) == 0) ? bl + 3 : $urandom_range(1, bl + 3);
		feed_delim(m);
		if ($urandom_range(0, 3) == 0 && delim_byte(m) != CH_CR) bad = CH_CR;
		else bad = rand_except(delim_byte(m));
		feed(bad);
	endtask

	task automatic data_and_close();
		repeat ($urandom_range(0, 3)) begin
			if ($urandom_range(0, 5) == 0) fake_delimiter();
			else feed(8'($urandom_range(0, 255)));
		end
		feed_delim(bnd_len_eff() + 4);
	endtask

	task automatic open_part();
		logic ended;
		ended = 1'b0;
		feed(CH_CR);
		feed(CH_LF);
		repeat ($urandom_range(0, 1)) begin
			if (!ended) begin
				repeat ($urandom_range(1, 5)) feed(name_char());
				if ($urandom_range(0, 7) == 0) begin
					ended = 1'b1;
				end else begin
					feed(CH_COLON);
					repeat ($urandom_range(0, 2)) feed($urandom_range(0, 1) ? CH_SP : CH_TAB);
					repeat ($urandom_range(0, 6)) feed(rand_except(CH_CR));
					feed(CH_CR);
					feed(CH_LF);
				end
			end
		end
		feed(CH_CR);
		feed(CH_LF);
	endtask

	task automatic finish_body();
		if ($urandom_range(0, 1)) begin
			feed(CH_HYPHEN);
			feed(CH_HYPHEN);
		end else begin
			case ($urandom_range(0, 3))
			0: feed(8'($urandom_range(8'h30, 8'h39)));
			1: begin
				feed(CH_CR);
				feed(rand_except(CH_LF));
			end
			2: begin
				feed(CH_HYPHEN);
				feed(rand_except(CH_HYPHEN));
			end
			default: begin
				feed(CH_CR);
				feed(CH_LF);
				feed(name_char());
				feed(8'($urandom_range(8'h30, 8'h39)));
			end
			endcase
		end
		repeat (8) feed(8'($urandom_range(0, 255)));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_events.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, got kind %0d value 0x%h",
					$time, kind, value);
				mismatches++;
			end else begin
				want = expected_events.pop_front();
				field_bad = 1'b0;
				if (kind !== want.kind) begin
					$display("%0t: kind expected %0d, got %0d", $time, want.kind, kind);
					field_bad = 1'b1;
				end
				if (value !== want.value) begin
					$display("%0t: value expected 0x%h, got 0x%h", $time, want.value, value);
					field_bad = 1'b1;
				end
				if (last_of_run !== want.last) begin
					$display("%0t: last_of_run expected %0b, got %0b", $time, want.last,
						last_of_run);
					field_bad = 1'b1;
				end
				if (field_bad) mismatches++;
			end
		end
		stall_cycle++;
		if (stall_cycle % 96 == 0) stall_mode = $urandom_range(0, 2);
		case (stall_mode)
		0: out_ready <= 1'b1;
		1: out_ready <= ($urandom_range(0, 2) != 0);
		default: out_ready <= (stall_cycle % 11) > 5;
		endcase
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		int ph;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_reg(REG_LEN, 64'd1);
		write_reg(REG_WORD0, 64'h42);
		cfg_valid <= 1'b0;
		foreach (script[i]) begin
			send_byte(script[i].b);
			classify_byte(script[i].b);
			if (script[i].typed)
				expected_events.push_back(parse_event_t'{script[i].kind, script[i].value, 1'b1});
			else
				foreach (byte_events[j]) expected_events.push_back(byte_events[j]);
		end
		ph = 0;
		while (ph < 6 || bytes_sent < 220) begin
			settle();
			configure(ph);
			data_and_close();
			open_part();
			ph++;
		end
		settle();
		configure(ph);
		data_and_close();
		finish_body();
		settle();
		repeat (40) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

[files.f]
src/mpb_pkg.sv
src/multipart_body_parser.sv
tb/sv/multipart_body_parser_test.sv
